FILE: rtl/fpm_pkg.sv
// shared types and constants for the truncating single-precision multiplier
package fpm_pkg;

	localparam int unsigned FracW = 23;
	localparam int unsigned ExpW  = 8;
	localparam int unsigned SigW  = FracW + 1;
	localparam int unsigned ProdW = 2 * SigW;
	localparam int unsigned LzW   = 6;
	localparam int unsigned EW    = 10;

	// 1024 - 127 + 1, folded into the 10-bit exponent sum
	localparam logic [EW-1:0] EXP_OFFSET = 10'd898;
	localparam logic [ExpW-1:0] EXP_MAX = 8'hff;

	typedef logic [31:0] word_t;
	typedef logic [ProdW-1:0] prod_t;
	typedef logic [LzW-1:0] lz_t;
	typedef logic signed [EW-1:0] exp_t;

endpackage

FILE: rtl/fp32_multiply_truncating.sv
// top level: four-stage pipelined truncating single-precision multiplier
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_ready, operand_a, operand_b | into block
//  output  | out_valid, out_ready, product            | out of block
//
// one item per cycle while the output is taken; an item is registered in s1, s2, s3 and s4, then product is valid
// stages: s1 significand multiply, s2 leading-zero count and exponent,
// s3 normalize shift, s4 exponent range check and packing (output register)
// the whole pipe advances together; it holds when the output is valid and not taken
// reset clears the stage valid bits only; payload registers are not reset
module fp32_multiply_truncating (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fpm_pkg::word_t      operand_a,
	input  fpm_pkg::word_t      operand_b,
	output logic                out_valid,
	input  logic                out_ready,
	output fpm_pkg::word_t      product
);
	import fpm_pkg::*;

	logic advance;

	logic v_s1, v_s2, v_s3, v_s4;
	logic sign_s1, sign_s2, sign_s3;
	logic [ExpW:0] esum_s1;
	prod_t prod_s1, prod_s2, norm_s3;
	lz_t lz_s2;
	exp_t e_s2, e_s3;
	word_t product_s4;

	// effective exponents and significands (subnormal: exponent 1, no hidden bit)
	logic [ExpW-1:0] ea, eb;
	logic [SigW-1:0] ma, mb;
	lz_t lz;

	assign advance  = !v_s4 || out_ready;
	assign in_ready = advance;

	always_comb begin
		ea = (operand_a[30:23] == '0) ? ExpW'(1) : operand_a[30:23];
		eb = (operand_b[30:23] == '0) ? ExpW'(1) : operand_b[30:23];
		ma = {operand_a[30:23] != '0, operand_a[FracW-1:0]};
		mb = {operand_b[30:23] != '0, operand_b[FracW-1:0]};
	end

	fpm_lzc u_lzc (
		.prod (prod_s1),
		.lz   (lz)
	);

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// final stage: range check on the signed exponent and packing
	logic [4:0] sh;
	prod_t shifted;
	word_t packed_w;

	always_comb begin
		sh      = 5'd1 - e_s3[4:0];
		shifted = norm_s3 >> sh;
		if (e_s3[EW-1]) begin
			// negative exponent: denormalize, or flush to zero at -23 and below
			if (e_s3 > -exp_t'(23)) begin
				packed_w = {sign_s3, {ExpW{1'b0}}, shifted[ProdW-1 -: FracW]};
			end else begin
				packed_w = {sign_s3, {(31){1'b0}}};
			end
		end else if (e_s3[ExpW]) begin
			// overflow to signed infinity
			packed_w = {sign_s3, EXP_MAX, {FracW{1'b0}}};
		end else begin
			packed_w = {sign_s3, e_s3[ExpW-1:0], norm_s3[ProdW-1 -: FracW]};
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			// s1: sign, exponent sum, significand product
			sign_s1 <= operand_a[31] ^ operand_b[31];
			esum_s1 <= {1'b0, ea} + {1'b0, eb};
			prod_s1 <= ma * mb;
			// s2: leading zeros and biased exponent in 10-bit two's complement
			sign_s2 <= sign_s1;
			prod_s2 <= prod_s1;
			lz_s2   <= lz;
			e_s2    <= exp_t'(EW'(esum_s1) + EXP_OFFSET - EW'(lz));
			// s3: shift out the leading one (zero product stays zero)
			sign_s3 <= sign_s2;
			e_s3    <= e_s2;
			norm_s3 <= (lz_s2 >= lz_t'(ProdW - 1)) ? '0 : (prod_s2 << (lz_s2 + lz_t'(1)));
			// s4: output register
			product_s4 <= packed_w;
		end
	end

	assign out_valid = v_s4;
	assign product   = product_s4;

endmodule

FILE: rtl/fpm_lzc.sv
// leading-zero count of the 48-bit significand product
module fpm_lzc (
	input  fpm_pkg::prod_t prod,
	output fpm_pkg::lz_t   lz
);
	import fpm_pkg::*;

	always_comb begin
		lz = lz_t'(ProdW);
		for (int i = 0; i < ProdW; i++) begin
			if (prod[i]) begin
				lz = lz_t'(ProdW - 1 - i);
			end
		end
	end

endmodule

FILE: test/tb.sv
// testbench for the truncating single-precision multiplier: predicted products checked in order
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fpm_pkg::*;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	// input channel
	logic  in_valid = 1'b0;
	logic  in_ready;
	word_t operand_a = '0;
	word_t operand_b = '0;
	// output channel
	logic  out_valid;
	logic  out_ready = 1'b0;
	word_t product;

	fp32_multiply_truncating DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.product(product)
	);

	word_t pending_products[$];
	int    errors = 0;
	bit    hold_receiver = 1'b0;
	bit    stall_free = 1'b0;

	// truncating multiply, computed independently of the rtl
	function automatic word_t mul_trunc(word_t a, word_t b);
		logic            sgn;
		logic [9:0]      ea, eb, raw;
		logic [23:0]     ma, mb;
		logic [47:0]     sig_prod, norm, shifted;
		int              lead_zeros;
		int              e;
		word_t           r;
		sgn = a[31] ^ b[31];
		ea = {2'b0, a[30:23]};
		eb = {2'b0, b[30:23]};
		ma = {1'b0, a[22:0]};
		mb = {1'b0, b[22:0]};
		// zero exponent reads as subnormal: exponent one, no hidden bit
		if (ea != 0) ma[23] = 1'b1; else ea = 10'd1;
		if (eb != 0) mb[23] = 1'b1; else eb = 10'd1;
		sig_prod = 48'(ma) * 48'(mb);
		lead_zeros = 48;
		for (int i = 47; i >= 0; i--)
			if (sig_prod[i]) begin
				lead_zeros = 47 - i;
				break;
			end
		norm = (lead_zeros >= 47) ? 48'd0 : (sig_prod << (lead_zeros + 1));
		// modulo 1024, so the 1024 offset drops out
		raw = ea + eb - 10'd127 + 10'd1 - 10'(lead_zeros);
		e = raw[9] ? int'(raw) - 1024 : int'(raw);
		if (e < 0) begin
			if (e > -23) begin
				shifted = norm >> (1 - e);
				r = {sgn, 8'd0, shifted[47:25]};
			end else begin
				r = {sgn, 31'd0};
			end
		end else if (e >= 256) begin
			r = {sgn, 8'hff, 23'd0};
		end else begin
			r = {sgn, e[7:0], norm[47:25]};
		end
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// send one operand pair; valid stays high until the transfer
	// valid drops only when a gap follows, so back-to-back pairs keep it high
	task automatic send_pair(word_t a, word_t b);
		int g;
		g = stall_free ? 0 : gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		operand_a <= a;
		operand_b <= b;
		do @(posedge clk); while (!in_ready);
		pending_products.push_back(mul_trunc(a, b));
		@(negedge clk);
	endtask

	// receiver: random stalls, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_receiver) out_ready <= 1'b0;
		else if (stall_free) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 99) < 70);
	end

	// product checker, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_products.size() == 0) begin
				$display("%0t: unexpected product, expected none, actual %h", $realtime, product);
				errors++;
			end else begin
				word_t want;
				want = pending_products.pop_front();
				if (product !== want) begin
					$display("%0t: product mismatch, expected %h, actual %h",
						$realtime, want, product);
					errors++;
				end
			end
		end
	end

	// fields at their extremes and the special cases
	task automatic test_directed();
		word_t pats[$];
		pats = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h007f_ffff,
			32'h0080_0000, 32'h3f80_0000, 32'h7f7f_ffff, 32'h7f80_0000,
			32'h7fc0_0000, 32'hffff_ffff, 32'h4000_0000};
		send_pair(32'h3f80_0000, 32'h3f80_0000);	// one times one
		send_pair(32'h7f7f_ffff, 32'h7f7f_ffff);	// overflow to infinity
		send_pair(32'h0000_0001, 32'h0000_0001);	// deep underflow to zero
		send_pair(32'h0080_0000, 32'h3f00_0000);	// just into subnormal range
		send_pair(32'h0080_0000, 32'h3400_0000);	// shifted right near the limit
		send_pair(32'h0000_0000, 32'h7f80_0000);	// zero significand, big exponent
		send_pair(32'h0000_0000, 32'hc000_0000);	// zero with sign
		send_pair(32'hffff_ffff, 32'hffff_ffff);	// nan patterns multiply as numbers
		send_pair(32'h007f_ffff, 32'h4b00_0000);	// subnormal rescaled
		for (int i = 0; i < 14; i++)
			send_pair(pats[$urandom_range(0, pats.size() - 1)],
				pats[$urandom_range(0, pats.size() - 1)]);
	endtask

	// random operands: full-range bits, plus exponents near the boundaries
	function automatic word_t rand_operand();
		word_t v;
		v = $urandom();
		case ($urandom_range(0, 3))
			0: v[30:23] = 8'($urandom_range(100, 154));
			1: v[30:23] = 8'($urandom_range(0, 3));
			2: v[30:23] = 8'($urandom_range(60, 200));
			default: ;
		endcase
		return v;
	endfunction

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) send_pair(rand_operand(), rand_operand());
	endtask

	// receiver held off while the sender keeps offering, so the pipe fills
	task automatic test_backpressure();
		fork
			begin
				hold_receiver = 1'b1;
				repeat (60) @(posedge clk);
				hold_receiver = 1'b0;
			end
			begin
				stall_free = 1'b1;
				for (int i = 0; i < 20; i++) send_pair(rand_operand(), rand_operand());
				in_valid <= 1'b0;
				stall_free = 1'b0;
			end
		join
		@(negedge clk);
	endtask

	// back-to-back transfers with no stalls on either side
	task automatic test_streaming();
		stall_free = 1'b1;
		test_random(100);
		stall_free = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_random(900);
		test_streaming();
		test_random(900);
		in_valid <= 1'b0;
		// drain, then let the pipe settle
		while (pending_products.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) $display("PASS fp32_multiply_truncating");
		else $display("FAIL fp32_multiply_truncating");
		$finish;
	end

	// run limit, far above the slowest legal run
	initial begin
		#2000000;
		$display("FAIL fp32_multiply_truncating");
		$finish;
	end
endmodule
